>>> rtl/core/bpw_pkg.sv
// ---------------------------------------------------------------------------
// Banked pixel writer package
// Shared widths, register indexes, controller states and the command and
// status bundles between the controller and the datapath.
// ---------------------------------------------------------------------------
package bpw_pkg;

   localparam int CoordW      = 16;
   localparam int ColourW     = 8;
   localparam int ScreenW     = 13;
   localparam int LineBytesW  = 15;
   localparam int PixelBytesW = 3;
   localparam int LayoutW     = 27;
   localparam int KbW         = 7;
   localparam int AddrW       = 27;
   localparam int KibShift    = 10;
   localparam int BankW       = 16;
   localparam int OffsetW     = 16;
   localparam int WordW       = 32;
   localparam int CsrIndexW   = 3;
   localparam int CsrDataW    = 27;
   localparam int DivDividendW = AddrW - KibShift;

   typedef enum logic [CsrIndexW-1:0] {
      REG_SCREEN_WIDTH  = 3'd0,
      REG_SCREEN_HEIGHT = 3'd1,
      REG_LINE_BYTES    = 3'd2,
      REG_PIXEL_BYTES   = 3'd3,
      REG_COLOUR_LAYOUT = 3'd4,
      REG_GRANULE_KB    = 3'd5,
      REG_WINDOW_KB     = 3'd6
   } reg_index_type;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_CHECK  = 5'b00010,
      ST_DIVIDE = 5'b00100,
      ST_EMIT   = 5'b01000,
      ST_REBANK = 5'b10000
   } state_type;

   typedef struct packed {
      logic capture;
      logic load_addr;
      logic div_start;
      logic rebank_start;
      logic apply_move;
      logic apply_rebank;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic stale;
      logic clipped;
      logic in_window;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

>>> rtl/core/bpw_req_if.sv
// ---------------------------------------------------------------------------
// Pixel write request channel
// Valid and ready handshake carrying one pixel write item.
// ---------------------------------------------------------------------------
interface bpw_req_if;
   logic              valid;
   logic              ready;
   logic signed [15:0] pos_x;
   logic signed [15:0] pos_y;
   logic [7:0]        red;
   logic [7:0]        green;
   logic [7:0]        blue;

   modport source (output valid, output pos_x, output pos_y, output red,
                   output green, output blue, input ready);
   modport sink   (input valid, input pos_x, input pos_y, input red,
                   input green, input blue, output ready);
endinterface

>>> rtl/core/bpw_rsp_if.sv
// ---------------------------------------------------------------------------
// Pixel write response channel
// Valid and ready handshake carrying one result item per pixel write.
// ---------------------------------------------------------------------------
interface bpw_rsp_if;
   logic        valid;
   logic        ready;
   logic        written;
   logic        bank_moved;
   logic [15:0] bank_number;
   logic [15:0] window_offset;
   logic [31:0] colour_word;
   logic [2:0]  byte_count;

   modport source (output valid, output written, output bank_moved,
                   output bank_number, output window_offset, output colour_word,
                   output byte_count, input ready);
   modport sink   (input valid, input written, input bank_moved,
                   input bank_number, input window_offset, input colour_word,
                   input byte_count, output ready);
endinterface

>>> rtl/core/bpw_div.sv
// ---------------------------------------------------------------------------
// Bank divider
// Restoring divider giving one quotient bit per cycle, used to turn a byte
// address in kilobytes into a bank number and remainder.
// ---------------------------------------------------------------------------
module bpw_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [bpw_pkg::DivDividendW-1:0]    dividend,
   input  logic [bpw_pkg::KbW-1:0]             divisor,
   output logic                                done,
   output logic [bpw_pkg::DivDividendW-1:0]    quotient,
   output logic [bpw_pkg::KbW-1:0]             remainder
);
   import bpw_pkg::*;

   localparam int CntW = $clog2(DivDividendW + 1);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [CntW-1:0]         cnt_ff, cnt_in;
   logic [DivDividendW-1:0] quo_ff, quo_in;
   logic [KbW-1:0]          rem_ff, rem_in;
   logic [KbW:0]            shifted;
   logic [KbW:0]            diff;
   logic                    fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[DivDividendW-1]};
      diff    = shifted - {1'b0, divisor};
      fits    = shifted >= {1'b0, divisor};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CntW'(DivDividendW);
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? diff[KbW-1:0] : shifted[KbW-1:0];
         quo_in = {quo_ff[DivDividendW-2:0], fits};
         cnt_in = cnt_ff - CntW'(1);
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

>>> rtl/core/bpw_ctrl.sv
// ---------------------------------------------------------------------------
// Banked pixel writer controller
// Sequences capture, window check, bank division and result hand-off.
// ---------------------------------------------------------------------------
module bpw_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  bpw_pkg::status_type  status,
   output bpw_pkg::cmd_type     cmd
);
   import bpw_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (status.stale) begin
               cmd.rebank_start = 1'b1;
               state_in         = ST_REBANK;
            end else begin
               req_ready = 1'b1;
               if (req_valid) begin
                  cmd.capture = 1'b1;
                  state_in    = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            cmd.load_addr = 1'b1;
            if (!status.clipped && !status.in_window) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIVIDE;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               cmd.apply_move = 1'b1;
               state_in       = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_REBANK: begin
            if (status.div_done) begin
               cmd.apply_rebank = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> (state_ff == ST_DIVIDE || state_ff == ST_REBANK))
      else $error("Divider finished outside a division state.");

   a_div_on_screen: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE |-> !status.clipped)
      else $error("Window move started for a clipped item.");

endmodule

>>> rtl/core/bpw_dp.sv
// ---------------------------------------------------------------------------
// Banked pixel writer datapath
// Configuration registers, colour packing, address multiply, window check,
// window state and the result register.
// ---------------------------------------------------------------------------
module bpw_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [bpw_pkg::CsrIndexW-1:0]     csr_index,
   input  logic [bpw_pkg::CsrDataW-1:0]      csr_wdata,
   input  logic [bpw_pkg::CoordW-1:0]        req_pos_x,
   input  logic [bpw_pkg::CoordW-1:0]        req_pos_y,
   input  logic [bpw_pkg::ColourW-1:0]       req_red,
   input  logic [bpw_pkg::ColourW-1:0]       req_green,
   input  logic [bpw_pkg::ColourW-1:0]       req_blue,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic                              rsp_written,
   output logic                              rsp_bank_moved,
   output logic [bpw_pkg::BankW-1:0]         rsp_bank_number,
   output logic [bpw_pkg::OffsetW-1:0]       rsp_window_offset,
   output logic [bpw_pkg::WordW-1:0]         rsp_colour_word,
   output logic [bpw_pkg::PixelBytesW-1:0]   rsp_byte_count,
   input  bpw_pkg::cmd_type                  cmd,
   output bpw_pkg::status_type               status
);
   import bpw_pkg::*;

   function automatic logic [ColourW-1:0] fit_component(input logic [ColourW-1:0] c,
                                                        input logic [3:0] size);
      logic [3:0] eff;
      begin
         eff = (size > 4'd8) ? 4'd8 : size;
         return c >> (4'd8 - eff);
      end
   endfunction

   function automatic logic [WordW-1:0] place(input logic [ColourW-1:0] v,
                                              input logic [4:0] pos);
      return {{(WordW-ColourW){1'b0}}, v} << pos;
   endfunction

   logic [ScreenW-1:0]     width_ff, width_in;
   logic [ScreenW-1:0]     height_ff, height_in;
   logic [LineBytesW-1:0]  line_bytes_ff, line_bytes_in;
   logic [PixelBytesW-1:0] pixel_bytes_ff, pixel_bytes_in;
   logic [LayoutW-1:0]     layout_ff, layout_in;
   logic [KbW-1:0]         granule_ff, granule_in;
   logic [KbW-1:0]         window_kb_ff, window_kb_in;

   logic [AddrW-1:0]       window_base_ff, window_base_in;
   logic [BankW-1:0]       bank_ff, bank_in;
   logic                   stale_ff, stale_in;
   logic                   moved_ff, moved_in;
   logic                   clip_ff, clip_in;
   logic [WordW-1:0]       colour_ff, colour_in;
   logic [AddrW-1:0]       prod_y_ff, prod_y_in;
   logic [OffsetW-1:0]     prod_x_ff, prod_x_in;
   logic [AddrW-1:0]       addr_ff, addr_in;

   logic                   out_valid_ff, out_valid_in;
   logic                   out_written_ff, out_written_in;
   logic                   out_moved_ff, out_moved_in;
   logic [BankW-1:0]       out_bank_ff, out_bank_in;
   logic [OffsetW-1:0]     out_offset_ff, out_offset_in;
   logic [WordW-1:0]       out_colour_ff, out_colour_in;
   logic [PixelBytesW-1:0] out_count_ff, out_count_in;

   logic [PixelBytesW-1:0] psize;
   logic [KbW-1:0]         wkb;
   logic [KbW-1:0]         granule_eff;
   logic [WordW-1:0]       colour_raw;
   logic [WordW-1:0]       colour_mask;
   logic [27:0]            prod_y_full;
   logic [AddrW-1:0]       addr_now;
   logic [AddrW:0]         window_end;
   logic [AddrW-1:0]       offset_full;
   logic [DivDividendW-1:0] div_dividend;
   logic                   div_done;
   logic [DivDividendW-1:0] div_quotient;
   logic [KbW-1:0]         div_remainder;

   // Effective pixel size, window size and granule after range folding.
   always_comb begin
      psize = pixel_bytes_ff;
      if (pixel_bytes_ff == '0) psize = PixelBytesW'(1);
      if (pixel_bytes_ff > PixelBytesW'(4)) psize = PixelBytesW'(4);
      wkb = window_kb_ff;
      if (window_kb_ff == '0) wkb = KbW'(1);
      if (window_kb_ff > KbW'(64)) wkb = KbW'(64);
      granule_eff = (granule_ff == '0) ? KbW'(1) : granule_ff;
   end

   always_comb begin
      width_in       = width_ff;
      height_in      = height_ff;
      line_bytes_in  = line_bytes_ff;
      pixel_bytes_in = pixel_bytes_ff;
      layout_in      = layout_ff;
      granule_in     = granule_ff;
      window_kb_in   = window_kb_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_SCREEN_WIDTH:  width_in       = csr_wdata[ScreenW-1:0];
            REG_SCREEN_HEIGHT: height_in      = csr_wdata[ScreenW-1:0];
            REG_LINE_BYTES:    line_bytes_in  = csr_wdata[LineBytesW-1:0];
            REG_PIXEL_BYTES:   pixel_bytes_in = csr_wdata[PixelBytesW-1:0];
            REG_COLOUR_LAYOUT: layout_in      = csr_wdata[LayoutW-1:0];
            REG_GRANULE_KB:    granule_in     = csr_wdata[KbW-1:0];
            REG_WINDOW_KB:     window_kb_in   = csr_wdata[KbW-1:0];
            default: ;
         endcase
      end
   end

   // Capture stage: clipping, colour packing and the two products.
   always_comb begin
      colour_raw = place(fit_component(req_red, layout_ff[3:0]), layout_ff[16:12])
                 | place(fit_component(req_green, layout_ff[7:4]), layout_ff[21:17])
                 | place(fit_component(req_blue, layout_ff[11:8]), layout_ff[26:22]);
      case (psize)
         3'd1:    colour_mask = 32'h0000_00FF;
         3'd2:    colour_mask = 32'h0000_FFFF;
         3'd3:    colour_mask = 32'h00FF_FFFF;
         default: colour_mask = 32'hFFFF_FFFF;
      endcase
      prod_y_full = {{(28-ScreenW){1'b0}}, req_pos_y[ScreenW-1:0]}
                  * {{(28-LineBytesW){1'b0}}, line_bytes_ff};
      clip_in   = clip_ff;
      colour_in = colour_ff;
      prod_y_in = prod_y_ff;
      prod_x_in = prod_x_ff;
      if (cmd.capture) begin
         clip_in = req_pos_x[CoordW-1] || req_pos_y[CoordW-1]
                || (req_pos_x >= {{(CoordW-ScreenW){1'b0}}, width_ff})
                || (req_pos_y >= {{(CoordW-ScreenW){1'b0}}, height_ff});
         colour_in = colour_raw & colour_mask;
         prod_y_in = prod_y_full[AddrW-1:0];
         prod_x_in = {{(OffsetW-ScreenW){1'b0}}, req_pos_x[ScreenW-1:0]}
                   * {{(OffsetW-PixelBytesW){1'b0}}, psize};
      end
   end

   // Check stage: byte address and window containment.
   always_comb begin
      addr_now   = prod_y_ff + {{(AddrW-OffsetW){1'b0}}, prod_x_ff};
      window_end = {1'b0, window_base_ff}
                 + {{(AddrW+1-KbW-KibShift){1'b0}}, wkb, {KibShift{1'b0}}};
      addr_in    = cmd.load_addr ? addr_now : addr_ff;
      div_dividend = cmd.rebank_start ? window_base_ff[AddrW-1:KibShift]
                                      : addr_now[AddrW-1:KibShift];
   end

   bpw_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start | cmd.rebank_start),
      .dividend  (div_dividend),
      .divisor   (granule_eff),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   // Window state: the new base is the address rounded down to a granule.
   always_comb begin
      window_base_in = window_base_ff;
      bank_in        = bank_ff;
      stale_in       = stale_ff;
      moved_in       = moved_ff;
      if (csr_wr_en && csr_index == REG_GRANULE_KB) stale_in = 1'b1;
      if (cmd.capture) moved_in = 1'b0;
      if (cmd.apply_move) begin
         window_base_in = {addr_ff[AddrW-1:KibShift]
                           - {{(DivDividendW-KbW){1'b0}}, div_remainder},
                           {KibShift{1'b0}}};
         bank_in  = div_quotient[BankW-1:0];
         moved_in = 1'b1;
         stale_in = 1'b0;
      end
      if (cmd.apply_rebank) begin
         bank_in  = div_quotient[BankW-1:0];
         stale_in = 1'b0;
      end
   end

   // Result register.
   always_comb begin
      offset_full    = addr_ff - window_base_ff;
      out_valid_in   = out_valid_ff;
      out_written_in = out_written_ff;
      out_moved_in   = out_moved_ff;
      out_bank_in    = out_bank_ff;
      out_offset_in  = out_offset_ff;
      out_colour_in  = out_colour_ff;
      out_count_in   = out_count_ff;
      if (rsp_ready) out_valid_in = 1'b0;
      if (cmd.emit) begin
         out_valid_in   = 1'b1;
         out_written_in = !clip_ff;
         out_moved_in   = moved_ff;
         out_bank_in    = bank_ff;
         out_offset_in  = clip_ff ? '0 : offset_full[OffsetW-1:0];
         out_colour_in  = clip_ff ? '0 : colour_ff;
         out_count_in   = psize;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff       <= ScreenW'(640);
         height_ff      <= ScreenW'(480);
         line_bytes_ff  <= LineBytesW'(1280);
         pixel_bytes_ff <= PixelBytesW'(2);
         layout_ff      <= '0;
         granule_ff     <= KbW'(64);
         window_kb_ff   <= KbW'(64);
         window_base_ff <= '0;
         bank_ff        <= '0;
         stale_ff       <= 1'b0;
         moved_ff       <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         width_ff       <= width_in;
         height_ff      <= height_in;
         line_bytes_ff  <= line_bytes_in;
         pixel_bytes_ff <= pixel_bytes_in;
         layout_ff      <= layout_in;
         granule_ff     <= granule_in;
         window_kb_ff   <= window_kb_in;
         window_base_ff <= window_base_in;
         bank_ff        <= bank_in;
         stale_ff       <= stale_in;
         moved_ff       <= moved_in;
         out_valid_ff   <= out_valid_in;
      end
      clip_ff        <= clip_in;
      colour_ff      <= colour_in;
      prod_y_ff      <= prod_y_in;
      prod_x_ff      <= prod_x_in;
      addr_ff        <= addr_in;
      out_written_ff <= out_written_in;
      out_moved_ff   <= out_moved_in;
      out_bank_ff    <= out_bank_in;
      out_offset_ff  <= out_offset_in;
      out_colour_ff  <= out_colour_in;
      out_count_ff   <= out_count_in;
   end

   assign status.stale     = stale_ff;
   assign status.clipped   = clip_ff;
   assign status.in_window = (addr_now >= window_base_ff) && ({1'b0, addr_now} < window_end);
   assign status.div_done  = div_done;
   assign status.out_free  = !out_valid_ff || rsp_ready;

   assign rsp_valid         = out_valid_ff;
   assign rsp_written       = out_written_ff;
   assign rsp_bank_moved    = out_moved_ff;
   assign rsp_bank_number   = out_bank_ff;
   assign rsp_window_offset = out_offset_ff;
   assign rsp_colour_word   = out_colour_ff;
   assign rsp_byte_count    = out_count_ff;

   a_move_below_addr: assert property (@(posedge clock) disable iff (reset)
      cmd.apply_move |=> (addr_ff >= window_base_ff) && (window_base_ff[KibShift-1:0] == '0))
      else $error("Moved window does not start at or below the pixel address.");

   a_emit_bank_current: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !stale_ff)
      else $error("Item handed out with a stale bank number.");

endmodule

>>> rtl/core/banked_pixel_writer.sv
// ---------------------------------------------------------------------------
// Banked pixel writer
// Clips a pixel write, packs its colour and places it in a banked window.
//
// The req_ch channel takes one pixel write item (pos_x, pos_y, red, green,
// blue); the rsp_ch channel returns one result item for every write, in
// order. The csr_ port writes one configuration register per cycle; the
// user is to write only while the block is idle, and the block itself
// does not enforce this; no read-back. When the window need not move, an
// item passes through capture, address check and result hand-off before
// the next acceptance. The address uses one registered multiply of row by
// line bytes. A window move runs a restoring divider one quotient bit per
// cycle over the 17-bit kilobyte address. After a write to the granule
// register the bank number is recomputed by the same divider before the
// next item is taken.
// Reset restores the register defaults and puts the window at bank 0.
// When the receiver stalls, the result waits in the output register and
// the block still accepts and works on the next item, holding it until
// the output register frees.
// ---------------------------------------------------------------------------
module banked_pixel_writer (
   input  logic                           clock,
   input  logic                           reset,
   bpw_req_if.sink                        req_ch,
   bpw_rsp_if.source                      rsp_ch,
   input  logic                           csr_wr_en,
   input  logic [bpw_pkg::CsrIndexW-1:0]  csr_index,
   input  logic [bpw_pkg::CsrDataW-1:0]   csr_wdata
);
   import bpw_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       req_ready;

   assign req_ch.ready = req_ready;

   bpw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bpw_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_pos_x         (req_ch.pos_x),
      .req_pos_y         (req_ch.pos_y),
      .req_red           (req_ch.red),
      .req_green         (req_ch.green),
      .req_blue          (req_ch.blue),
      .rsp_ready         (rsp_ch.ready),
      .rsp_valid         (rsp_ch.valid),
      .rsp_written       (rsp_ch.written),
      .rsp_bank_moved    (rsp_ch.bank_moved),
      .rsp_bank_number   (rsp_ch.bank_number),
      .rsp_window_offset (rsp_ch.window_offset),
      .rsp_colour_word   (rsp_ch.colour_word),
      .rsp_byte_count    (rsp_ch.byte_count),
      .cmd               (cmd),
      .status            (status)
   );

endmodule
